FILE: rtl/lrcg_pkg.sv
// ----------------------------------------------------------------------------
// lrcg_pkg
// Shared types, register codes and reset values for the lidar ROI guard.
// ----------------------------------------------------------------------------
package lrcg_pkg;

   // Default fixed-point and datapath settings.
   localparam int LRCG_COEF_FRAC_BITS = 14;
   localparam int LRCG_COORD_WIDTH    = 18;
   localparam int LRCG_QUEUE_DEPTH    = 4;

   // Register index codes on the configuration port.
   typedef enum logic [2:0] {
      REG_XFORM_ROW_X   = 3'd0,
      REG_XFORM_ROW_Y   = 3'd1,
      REG_XFORM_ROW_Z   = 3'd2,
      REG_EGO_BOX       = 3'd3,
      REG_ROI_BOX       = 3'd4,
      REG_HEIGHT_WINDOW = 3'd5,
      REG_MIN_POINTS    = 3'd6,
      REG_MIN_FRAMES    = 3'd7
   } reg_index_type;

   // Register reset values.
   localparam logic [63:0] XFORM_ROW_X_RESET = 64'd16384;
   localparam logic [63:0] XFORM_ROW_Y_RESET = 64'd1073741824;
   localparam logic [63:0] XFORM_ROW_Z_RESET = 64'd70368744177664;
   localparam logic [15:0] MIN_POINTS_RESET  = 16'd1;
   localparam logic [7:0]  MIN_FRAMES_RESET  = 8'd1;

   // Saturation limits of the frame counters.
   localparam logic [15:0] POINT_COUNT_MAX = 16'hFFFF;
   localparam logic [7:0]  STREAK_MAX      = 8'hFF;

   // Configuration registers as seen by the front and back parts.
   typedef struct packed {
      logic [63:0] xform_row_x;
      logic [63:0] xform_row_y;
      logic [63:0] xform_row_z;
      logic [47:0] ego_box;
      logic [47:0] roi_box;
      logic [31:0] height_window;
      logic [15:0] min_points;
      logic [7:0]  min_frames;
   } cfg_type;

   // One classified point word passed from the front to the back.
   typedef struct packed {
      logic hit;
      logic last;
   } point_rec_type;

endpackage

FILE: rtl/lrcg_front.sv
// ----------------------------------------------------------------------------
// lrcg_front
// Point transform and zone classification pipeline.
// Stage 1 holds the nine coefficient products, stage 2 the rounded
// vehicle-frame coordinates; the zone tests feed the queue from stage 2.
// ----------------------------------------------------------------------------
module lrcg_front
   import lrcg_pkg::*;
#(
   parameter int COEF_FRAC_BITS = LRCG_COEF_FRAC_BITS,
   parameter int COORD_WIDTH    = LRCG_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] x_mm,
   input  logic signed [COORD_WIDTH-1:0] y_mm,
   input  logic signed [COORD_WIDTH-1:0] z_mm,
   input  logic                          point_valid,
   input  logic                          last_in_frame,
   output logic                          push_valid,
   output point_rec_type                 push_data,
   input  logic                          queue_full
);

   localparam int PROD_W = 16 + COORD_WIDTH;
   localparam int OFFS_W = 16 + COEF_FRAC_BITS;
   localparam int ACC_W  = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 3;
   localparam int RES_W  = ACC_W - COEF_FRAC_BITS;
   localparam int CMP_W  = RES_W + 2;
   localparam logic signed [ACC_W-1:0] HALF_LSB =
      ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

   logic signed [COORD_WIDTH-1:0] coord [3];
   logic [63:0]                   row [3];

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_point_ff, s1_last_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];

   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_point_ff, s2_last_ff;
   logic signed [RES_W-1:0] veh_ff [3];
   logic signed [RES_W-1:0] veh_in [3];

   logic advance;

   assign coord[0] = x_mm;
   assign coord[1] = y_mm;
   assign coord[2] = z_mm;
   assign row[0]   = cfg.xform_row_x;
   assign row[1]   = cfg.xform_row_y;
   assign row[2]   = cfg.xform_row_z;

   // The whole pipe moves unless the last stage holds a word the queue cannot take.
   assign advance  = !s2_valid_ff || !queue_full;
   assign in_ready = advance;

   // Coefficient products for each row and axis.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = PROD_W'($signed(row[r][16*c +: 16]) * coord[c]);
         end
      end
   end

   // Row sums with offset and rounding, then floor shift to whole millimeters.
   always_comb begin
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] offs;
      for (int r = 0; r < 3; r++) begin
         offs = ACC_W'($signed(row[r][63:48])) <<< COEF_FRAC_BITS;
         acc  = ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1]) +
                ACC_W'(prod_ff[r][2]) + offs + HALF_LSB;
         veh_in[r] = RES_W'(acc >>> COEF_FRAC_BITS);
      end
   end

   assign s1_valid_in = advance ? in_valid    : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (advance) begin
         s1_point_ff <= point_valid;
         s1_last_ff  <= last_in_frame;
         prod_ff     <= prod_in;
         s2_point_ff <= s1_point_ff;
         s2_last_ff  <= s1_last_ff;
         veh_ff      <= veh_in;
      end
   end

   // Zone tests on the vehicle-frame point.
   always_comb begin
      logic signed [CMP_W-1:0] vx, vy, vz, ax;
      logic signed [CMP_W-1:0] ego_fwd, ego_bwd, ego_hw;
      logic signed [CMP_W-1:0] roi_fwd, roi_bwd, roi_hw;
      logic signed [CMP_W-1:0] h_min, h_max;
      logic                    on_ego, off_height, off_roi;
      vx = CMP_W'(veh_ff[0]);
      vy = CMP_W'(veh_ff[1]);
      vz = CMP_W'(veh_ff[2]);
      ax = (vx < 0) ? -vx : vx;
      ego_fwd = $signed(CMP_W'(cfg.ego_box[15:0]));
      ego_bwd = $signed(CMP_W'(cfg.ego_box[31:16]));
      ego_hw  = $signed(CMP_W'(cfg.ego_box[47:32]));
      roi_fwd = $signed(CMP_W'(cfg.roi_box[15:0]));
      roi_bwd = $signed(CMP_W'(cfg.roi_box[31:16]));
      roi_hw  = $signed(CMP_W'(cfg.roi_box[47:32]));
      h_min   = CMP_W'($signed(cfg.height_window[15:0]));
      h_max   = CMP_W'($signed(cfg.height_window[31:16]));
      on_ego     = (vy < ego_fwd) && (vy > -ego_bwd) && (ax < ego_hw);
      off_height = (vz < h_min) || (vz > h_max);
      off_roi    = (vy > roi_fwd) || (vy < -roi_bwd) || (ax > roi_hw);
      push_data.hit  = s2_point_ff && !on_ego && !off_height && !off_roi;
      push_data.last = s2_last_ff;
   end

   assign push_valid = s2_valid_ff && !queue_full;

endmodule

FILE: rtl/lrcg_queue.sv
// ----------------------------------------------------------------------------
// lrcg_queue
// Short first-in first-out queue of classified point words.
// ----------------------------------------------------------------------------
module lrcg_queue
   import lrcg_pkg::*;
#(
   parameter int DEPTH = LRCG_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  point_rec_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output point_rec_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   point_rec_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and fill-count updates, wrapping at any depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Storage and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/lrcg_back.sv
// ----------------------------------------------------------------------------
// lrcg_back
// Per-frame point counting, risky-frame streak and result register.
// ----------------------------------------------------------------------------
module lrcg_back
   import lrcg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          head_valid,
   input  point_rec_type head_data,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_is_collision,
   output logic          rsp_frame_risky,
   output logic [7:0]    rsp_hit_streak,
   output logic [15:0]   rsp_roi_points
);

   logic [15:0] count_ff, count_in;
   logic [7:0]  streak_ff, streak_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        collision_ff, risky_ff;
   logic [7:0]  out_streak_ff;
   logic [15:0] out_points_ff;
   logic [15:0] count_new;
   logic [15:0] need;
   logic        risky;
   logic        pop_last;

   // A non-last word is always taken; a last word needs a free result slot.
   assign pop      = head_valid && (!head_data.last || !rsp_valid_ff || rsp_ready);
   assign pop_last = pop && head_data.last;

   // Count and streak arithmetic.
   always_comb begin
      count_new = (head_data.hit && count_ff != POINT_COUNT_MAX) ?
                  count_ff + 16'd1 : count_ff;
      need      = (cfg.min_points == '0) ? 16'd1 : cfg.min_points;
      risky     = (count_new >= need);
      count_in  = count_ff;
      streak_in = streak_ff;
      if (pop) begin
         count_in = head_data.last ? '0 : count_new;
      end
      if (pop_last) begin
         if (!risky) begin
            streak_in = '0;
         end else if (streak_ff != STREAK_MAX) begin
            streak_in = streak_ff + 8'd1;
         end
      end
      rsp_valid_in = pop_last || (rsp_valid_ff && !rsp_ready);
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         streak_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         streak_ff    <= streak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop_last) begin
         collision_ff  <= (streak_in >= cfg.min_frames);
         risky_ff      <= risky;
         out_streak_ff <= streak_in;
         out_points_ff <= count_new;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_collision = collision_ff;
   assign rsp_frame_risky  = risky_ff;
   assign rsp_hit_streak   = out_streak_ff;
   assign rsp_roi_points   = out_points_ff;

`ifndef SYNTHESIS
   // Closing a frame always clears the point count.
   a_count_clears: assert property (@(posedge clock) disable iff (reset)
      pop_last |=> (count_ff == '0))
      else $error("point count not cleared after frame end");

   // The point count holds at its ceiling within a frame.
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      (pop && !head_data.last && count_ff == POINT_COUNT_MAX)
      |=> (count_ff == POINT_COUNT_MAX))
      else $error("point count wrapped");

   // A new result only appears after a frame end was taken from the queue.
   a_rsp_from_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pop_last))
      else $error("result raised without a frame end");

   // A risky frame always carries a nonzero streak, a clean one a zero streak.
   a_risky_streak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (risky_ff == (out_streak_ff != '0)))
      else $error("risky flag and streak disagree");
`endif

endmodule

FILE: rtl/lidar_roi_collision_guard_unit.sv
// ----------------------------------------------------------------------------
// lidar_roi_collision_guard_unit
// Lidar point collision guard: transform, zone tests, per-frame counting.
// ----------------------------------------------------------------------------
// Throughput: one point word per cycle while the queue has room, set by the two-stage transform pipe.
// Path: after acceptance, a frame-end point passes the second transform stage,
// the queue write and the result register before its result shows.
// A result waiting on rsp_ready stalls the back only at the next frame end.
// Reset is synchronous: registers return to defaults, counts and queue clear.
module lidar_roi_collision_guard_unit
   import lrcg_pkg::*;
#(
   parameter int COEF_FRAC_BITS = LRCG_COEF_FRAC_BITS,
   parameter int COORD_WIDTH    = LRCG_COORD_WIDTH,
   parameter int QUEUE_DEPTH    = LRCG_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [2:0]                    csr_index,
   input  logic [63:0]                   csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_x_mm,
   input  logic signed [COORD_WIDTH-1:0] req_y_mm,
   input  logic signed [COORD_WIDTH-1:0] req_z_mm,
   input  logic                          req_point_valid,
   input  logic                          req_last_in_frame,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_collision,
   output logic                          rsp_frame_risky,
   output logic [7:0]                    rsp_hit_streak,
   output logic [15:0]                   rsp_roi_points
);

   cfg_type       cfg_ff, cfg_in;
   logic          push_valid;
   point_rec_type push_data;
   logic          queue_full;
   logic          pop;
   logic          head_valid;
   point_rec_type head_data;

   // Configuration register writes, masked to each register's width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_XFORM_ROW_X:   cfg_in.xform_row_x   = csr_wr_data;
            REG_XFORM_ROW_Y:   cfg_in.xform_row_y   = csr_wr_data;
            REG_XFORM_ROW_Z:   cfg_in.xform_row_z   = csr_wr_data;
            REG_EGO_BOX:       cfg_in.ego_box       = csr_wr_data[47:0];
            REG_ROI_BOX:       cfg_in.roi_box       = csr_wr_data[47:0];
            REG_HEIGHT_WINDOW: cfg_in.height_window = csr_wr_data[31:0];
            REG_MIN_POINTS:    cfg_in.min_points    = csr_wr_data[15:0];
            REG_MIN_FRAMES:    cfg_in.min_frames    = csr_wr_data[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.xform_row_x   <= XFORM_ROW_X_RESET;
         cfg_ff.xform_row_y   <= XFORM_ROW_Y_RESET;
         cfg_ff.xform_row_z   <= XFORM_ROW_Z_RESET;
         cfg_ff.ego_box       <= '0;
         cfg_ff.roi_box       <= '0;
         cfg_ff.height_window <= '0;
         cfg_ff.min_points    <= MIN_POINTS_RESET;
         cfg_ff.min_frames    <= MIN_FRAMES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: transform and classify each point word.
   lrcg_front #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .COORD_WIDTH    (COORD_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .x_mm          (req_x_mm),
      .y_mm          (req_y_mm),
      .z_mm          (req_z_mm),
      .point_valid   (req_point_valid),
      .last_in_frame (req_last_in_frame),
      .push_valid    (push_valid),
      .push_data     (push_data),
      .queue_full    (queue_full)
   );

   // Queue between the front and the back.
   lrcg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Back: frame counting and results.
   lrcg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head_data        (head_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_collision (rsp_is_collision),
      .rsp_frame_risky  (rsp_frame_risky),
      .rsp_hit_streak   (rsp_hit_streak),
      .rsp_roi_points   (rsp_roi_points)
   );

endmodule

FILE: bench/lidar_roi_collision_guard_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_roi_collision_guard_unit_checker
// Passive frame-result checker for the lidar ROI collision guard. It tracks
// register writes, runs every accepted valid point through its own transform
// and zone tests, and keeps the frame verdicts it expects. Each result word
// is compared field by field against the oldest pending verdict.
// ----------------------------------------------------------------------------
module lidar_roi_collision_guard_unit_checker
   import lrcg_pkg::*;
(
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [2:0]                         csr_index,
   input  logic [63:0]                        csr_wr_data,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [LRCG_COORD_WIDTH-1:0] req_x_mm,
   input  logic signed [LRCG_COORD_WIDTH-1:0] req_y_mm,
   input  logic signed [LRCG_COORD_WIDTH-1:0] req_z_mm,
   input  logic                               req_point_valid,
   input  logic                               req_last_in_frame,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_is_collision,
   input  logic                               rsp_frame_risky,
   input  logic [7:0]                         rsp_hit_streak,
   input  logic [15:0]                        rsp_roi_points,
   output int                                 mismatch_count,
   output int                                 frames_pending
);

   localparam int FRAC = LRCG_COEF_FRAC_BITS;

   typedef struct packed {
      logic        collision;
      logic        risky;
      logic [7:0]  streak;
      logic [15:0] points;
   } frame_verdict_type;

   // Shadow copy of the registers and of the per-frame state.
   cfg_type           cfg;
   logic [15:0]       roi_count;
   logic [7:0]        risky_streak;
   frame_verdict_type verdict_q[$];

   // Prints one line for each mismatch and counts it.
   task automatic report_mismatch(input string what);
      $display("[%0t] frame result error: %s", $time, what);
      mismatch_count++;
   endtask

   // One row of the transform, rounded to whole mm with halves going upward.
   function automatic longint vehicle_coord(input logic [63:0] row, input longint px,
                                            input longint py, input longint pz);
      longint acc;
      acc = longint'($signed(row[15:0])) * px + longint'($signed(row[31:16])) * py
          + longint'($signed(row[47:32])) * pz
          + longint'($signed(row[63:48])) * (longint'(1) << FRAC)
          + (longint'(1) << (FRAC - 1));
      return acc >>> FRAC;
   endfunction

   // True when a sensor point lands in the protected zone in vehicle frame.
   function automatic bit point_in_zone(input longint px, input longint py, input longint pz);
      longint vx, vy, vz, ax;
      vx = vehicle_coord(cfg.xform_row_x, px, py, pz);
      vy = vehicle_coord(cfg.xform_row_y, px, py, pz);
      vz = vehicle_coord(cfg.xform_row_z, px, py, pz);
      ax = (vx < 0) ? -vx : vx;
      // Returns off the ego body itself, with strict bounds.
      if (vy < longint'(cfg.ego_box[15:0]) && vy > -longint'(cfg.ego_box[31:16]) &&
          ax < longint'(cfg.ego_box[47:32])) begin
         return 1'b0;
      end
      if (vz < longint'($signed(cfg.height_window[15:0])) ||
          vz > longint'($signed(cfg.height_window[31:16]))) begin
         return 1'b0;
      end
      if (vy > longint'(cfg.roi_box[15:0]) || vy < -longint'(cfg.roi_box[31:16]) ||
          ax > longint'(cfg.roi_box[47:32])) begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      frame_verdict_type want;
      logic [15:0]       need;
      logic              risky;
      if (reset) begin
         cfg.xform_row_x   = XFORM_ROW_X_RESET;
         cfg.xform_row_y   = XFORM_ROW_Y_RESET;
         cfg.xform_row_z   = XFORM_ROW_Z_RESET;
         cfg.ego_box       = '0;
         cfg.roi_box       = '0;
         cfg.height_window = '0;
         cfg.min_points    = MIN_POINTS_RESET;
         cfg.min_frames    = MIN_FRAMES_RESET;
         roi_count         = '0;
         risky_streak      = '0;
         verdict_q.delete();
         mismatch_count    = 0;
         frames_pending   <= 0;
      end else begin
         // Register writes; narrow registers keep only their low bits.
         if (csr_wr_en) begin
            case (reg_index_type'(csr_index))
               REG_XFORM_ROW_X:   cfg.xform_row_x   = csr_wr_data;
               REG_XFORM_ROW_Y:   cfg.xform_row_y   = csr_wr_data;
               REG_XFORM_ROW_Z:   cfg.xform_row_z   = csr_wr_data;
               REG_EGO_BOX:       cfg.ego_box       = csr_wr_data[47:0];
               REG_ROI_BOX:       cfg.roi_box       = csr_wr_data[47:0];
               REG_HEIGHT_WINDOW: cfg.height_window = csr_wr_data[31:0];
               REG_MIN_POINTS:    cfg.min_points    = csr_wr_data[15:0];
               REG_MIN_FRAMES:    cfg.min_frames    = csr_wr_data[7:0];
               default: ;
            endcase
         end

         // The result side goes first, so a stray word never meets a fresh verdict.
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("result word with no frame pending");
            end else begin
               want = verdict_q.pop_front();
               if (rsp_is_collision !== want.collision) begin
                  report_mismatch($sformatf("is_collision %b, expected %b",
                                            rsp_is_collision, want.collision));
               end
               if (rsp_frame_risky !== want.risky) begin
                  report_mismatch($sformatf("frame_risky %b, expected %b",
                                            rsp_frame_risky, want.risky));
               end
               if (rsp_hit_streak !== want.streak) begin
                  report_mismatch($sformatf("hit_streak %0d, expected %0d",
                                            rsp_hit_streak, want.streak));
               end
               if (rsp_roi_points !== want.points) begin
                  report_mismatch($sformatf("roi_points %0d, expected %0d",
                                            rsp_roi_points, want.points));
               end
            end
         end

         // Count the point, and close the frame on its last word.
         if (req_valid && req_ready) begin
            if (req_point_valid && roi_count != POINT_COUNT_MAX &&
                point_in_zone(longint'(req_x_mm), longint'(req_y_mm), longint'(req_z_mm))) begin
               roi_count++;
            end
            if (req_last_in_frame) begin
               need  = (cfg.min_points == '0) ? 16'd1 : cfg.min_points;
               risky = (roi_count >= need);
               if (!risky) begin
                  risky_streak = '0;
               end else if (risky_streak != STREAK_MAX) begin
                  risky_streak++;
               end
               want.collision = (risky_streak >= cfg.min_frames);
               want.risky     = risky;
               want.streak    = risky_streak;
               want.points    = roi_count;
               verdict_q.push_back(want);
               roi_count = '0;
            end
         end

         frames_pending <= verdict_q.size();
      end
   end

endmodule

FILE: bench/lidar_roi_collision_guard_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_roi_collision_guard_unit_test
// Drives point words into the collision guard and gives the verdict. A short
// directed part covers the box edges, rounding of halves and the zero-limit
// cases; random phases follow under many register settings, including a long
// risky streak. The checker beside the block predicts and compares every
// frame result.
// ----------------------------------------------------------------------------
module lidar_roi_collision_guard_unit_test;
   import lrcg_pkg::*;

   localparam int CW            = LRCG_COORD_WIDTH;
   localparam int CMAX          = (1 << (CW - 1)) - 1;
   localparam int CMIN          = -(1 << (CW - 1));
   localparam int SETTLE_CYCLES = 8;

   // A wide-open zone, for use with the reset transform that passes points straight through.
   localparam logic [63:0] OPEN_ROI    = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [63:0] OPEN_HEIGHT = 64'h0000_0000_7FFF_8000;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 csr_wr_en         = 1'b0;
   logic [2:0]           csr_index         = '0;
   logic [63:0]          csr_wr_data       = '0;
   logic                 req_valid         = 1'b0;
   logic                 req_ready;
   logic signed [CW-1:0] req_x_mm          = '0;
   logic signed [CW-1:0] req_y_mm          = '0;
   logic signed [CW-1:0] req_z_mm          = '0;
   logic                 req_point_valid   = 1'b0;
   logic                 req_last_in_frame = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready         = 1'b0;
   logic                 rsp_is_collision;
   logic                 rsp_frame_risky;
   logic [7:0]           rsp_hit_streak;
   logic [15:0]          rsp_roi_points;

   int mismatch_count;
   int frames_pending;
   bit idle_on     = 1'b1;
   int points_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lidar_roi_collision_guard_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_x_mm          (req_x_mm),
      .req_y_mm          (req_y_mm),
      .req_z_mm          (req_z_mm),
      .req_point_valid   (req_point_valid),
      .req_last_in_frame (req_last_in_frame),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_collision  (rsp_is_collision),
      .rsp_frame_risky   (rsp_frame_risky),
      .rsp_hit_streak    (rsp_hit_streak),
      .rsp_roi_points    (rsp_roi_points)
   );

   lidar_roi_collision_guard_unit_checker frame_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_x_mm          (req_x_mm),
      .req_y_mm          (req_y_mm),
      .req_z_mm          (req_z_mm),
      .req_point_valid   (req_point_valid),
      .req_last_in_frame (req_last_in_frame),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_collision  (rsp_is_collision),
      .rsp_frame_risky   (rsp_frame_risky),
      .rsp_hit_streak    (rsp_hit_streak),
      .rsp_roi_points    (rsp_roi_points),
      .mismatch_count    (mismatch_count),
      .frames_pending    (frames_pending)
   );

   // The result side stalls about a third of the cycles while idling is on.
   always @(posedge clock) begin
      rsp_ready <= !idle_on || ($urandom_range(0, 99) >= 33);
   end

   task automatic write_reg(input reg_index_type idx, input logic [63:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // Writes all eight registers back to back; the block must be idle.
   task automatic load_config(input logic [63:0] row_x, input logic [63:0] row_y,
                              input logic [63:0] row_z, input logic [63:0] ego,
                              input logic [63:0] roi, input logic [63:0] height,
                              input logic [63:0] min_pts, input logic [63:0] min_frm);
      write_reg(REG_XFORM_ROW_X, row_x);
      write_reg(REG_XFORM_ROW_Y, row_y);
      write_reg(REG_XFORM_ROW_Z, row_z);
      write_reg(REG_EGO_BOX, ego);
      write_reg(REG_ROI_BOX, roi);
      write_reg(REG_HEIGHT_WINDOW, height);
      write_reg(REG_MIN_POINTS, min_pts);
      write_reg(REG_MIN_FRAMES, min_frm);
      csr_wr_en <= 1'b0;
   endtask

   // Holds the sender until every frame result is back and the pipe is empty.
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Presents one point word and waits until it is taken.
   task automatic send_point(input int x, input int y, input int z,
                             input bit pv, input bit last);
      while (idle_on && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_x_mm          <= CW'(x);
      req_y_mm          <= CW'(y);
      req_z_mm          <= CW'(z);
      req_point_valid   <= pv;
      req_last_in_frame <= last;
      do @(posedge clock); while (!req_ready);
      points_sent++;
   endtask

   // A span of zero gives any value the coordinate port can carry.
   function automatic int rand_coord(input int span);
      logic [31:0] r;
      if (span == 0) begin
         r = $urandom();
         return int'($signed(r[CW-1:0]));
      end
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return 16'h4000;
         1: return 16'hC000;
         2: return 16'h0000;
         3: return 16'($urandom());
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic [63:0] rand_row();
      logic [15:0] offset;
      if ($urandom_range(0, 3) == 0) begin
         offset = 16'($urandom());
      end else begin
         offset = 16'(int'($urandom_range(0, 3000)) - 1500);
      end
      return {offset, rand_coef(), rand_coef(), rand_coef()};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Random boxes around the vehicle; the narrow registers get junk high bits.
   task automatic load_random_config();
      logic [63:0] ego, roi, height, min_pts, min_frm;
      ego     = rand64();
      roi     = rand64();
      height  = rand64();
      min_pts = rand64();
      min_frm = rand64();
      if ($urandom_range(0, 7) != 0) begin
         ego[15:0]  = 16'($urandom_range(0, 800));
         ego[31:16] = 16'($urandom_range(0, 800));
         ego[47:32] = 16'($urandom_range(0, 600));
         roi[15:0]  = 16'($urandom_range(500, 4000));
         roi[31:16] = 16'($urandom_range(0, 3000));
         roi[47:32] = 16'($urandom_range(100, 3000));
      end
      if ($urandom_range(0, 7) != 0) begin
         height[15:0]  = 16'(int'($urandom_range(0, 2000)) - 2000);
         height[31:16] = 16'($urandom_range(0, 2500));
      end
      min_pts[15:0] = 16'($urandom_range(0, 4));
      min_frm[7:0]  = 8'($urandom_range(0, 4));
      load_config(rand_row(), rand_row(), rand_row(), ego, roi, height, min_pts, min_frm);
   endtask

   // One frame of random length; noisy frames mix in wild and invalid points.
   task automatic send_random_frame(input int max_len, input int span, input bit noisy);
      int len;
      bit wild;
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) begin
         wild = noisy && ($urandom_range(0, 3) == 0);
         send_point(rand_coord(wild ? 0 : span), rand_coord(wild ? 0 : span),
                    rand_coord(wild ? 0 : span),
                    !noisy || ($urandom_range(0, 9) != 0), i == len - 1);
      end
      // Now and then the sender waits for every result before going on.
      if ($urandom_range(0, 39) == 0) begin
         settle_block();
      end
   endtask

   initial begin
      int target;
      int max_len;
      int span;
      bit noisy;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: identity transform, zone shrunk to the origin.
      send_point(0, 0, 0, 1'b1, 1'b0);
      send_point(0, 0, 0, 1'b0, 1'b1);
      send_point(CMAX, CMIN, CMAX, 1'b1, 1'b1);
      send_point(CMIN, CMAX, CMIN, 1'b1, 1'b0);
      send_point(0, 0, 0, 1'b1, 1'b1);
      send_point(0, 0, 0, 1'b1, 1'b1);
      settle_block();

      // Half-scale x, small ego box, zero limits: box edges and rounding.
      load_config(64'h0000_0000_0000_2000, XFORM_ROW_Y_RESET, XFORM_ROW_Z_RESET,
                  64'h0000_0032_0064_0064, 64'h0000_012C_01F4_03E8,
                  64'h0000_0000_00C8_FF38, 64'd0, 64'd0);
      send_point(0, 0, 0, 1'b1, 1'b0);
      send_point(0, 100, 0, 1'b1, 1'b0);
      send_point(0, -100, 0, 1'b1, 1'b0);
      send_point(99, 0, 0, 1'b1, 1'b0);
      send_point(-99, 0, 0, 1'b1, 1'b0);
      send_point(-101, 0, 0, 1'b1, 1'b0);
      send_point(600, 500, 0, 1'b1, 1'b0);
      send_point(602, 500, 0, 1'b1, 1'b0);
      send_point(0, 1000, 0, 1'b1, 1'b0);
      send_point(0, 1001, 0, 1'b1, 1'b0);
      send_point(0, -500, 0, 1'b1, 1'b0);
      send_point(0, -501, 0, 1'b1, 1'b0);
      send_point(0, 500, 200, 1'b1, 1'b0);
      send_point(0, 500, -201, 1'b1, 1'b0);
      send_point(0, 0, 0, 1'b0, 1'b1);
      // An empty frame still flags collision when no risky frames are needed.
      send_point(0, 0, 0, 1'b0, 1'b1);

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 10; phase++) begin
         settle_block();
         idle_on = (phase != 6);
         max_len = (phase == 8) ? 40 : 8;
         span    = 3000;
         noisy   = 1'b1;
         target  = 120;
         case (phase)
            0: begin
               // Everything maps to the origin, so every valid point counts.
               load_config(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
               target = 80;
            end
            1: begin
               load_config('1, '1, '1, '1, '1, '1, '1, '1);
               target = 80;
            end
            2: begin
               // Single-point risky frames, long enough to saturate the streak.
               load_config(XFORM_ROW_X_RESET, XFORM_ROW_Y_RESET, XFORM_ROW_Z_RESET,
                           64'd0, OPEN_ROI, OPEN_HEIGHT, 64'd1, 64'd255);
               max_len = 1;
               span    = 20000;
               noisy   = 1'b0;
               target  = 300;
            end
            default: load_random_config();
         endcase
         target = points_sent + target;
         while (points_sent < target) send_random_frame(max_len, span, noisy);
      end

      settle_block();
      if (mismatch_count == 0) begin
         $display("lidar_roi_collision_guard_unit: match");
      end else begin
         $display("lidar_roi_collision_guard_unit: mismatch");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5ms;
      $display("lidar_roi_collision_guard_unit: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
rtl/lrcg_pkg.sv
rtl/lrcg_front.sv
rtl/lrcg_queue.sv
rtl/lrcg_back.sv
rtl/lidar_roi_collision_guard_unit.sv
bench/lidar_roi_collision_guard_unit_checker.sv
bench/lidar_roi_collision_guard_unit_test.sv
